[rtl/lhfm_pkg.sv]
`timescale 1ns / 1ps
package lhfm_pkg;

  localparam int NUM_DEVICES = 6;
  localparam int DEV_W       = $clog2(NUM_DEVICES);
  localparam int FAULT_W     = $clog2(NUM_DEVICES + 1);
  localparam int TIME_W      = 32;
  localparam int TIMEOUT_W   = 16;
  localparam int LEVEL_W     = 16;
  localparam int BEEP_W      = 15;
  localparam int BLINK_WRAP  = 60;
  localparam int BLINK_W     = $clog2(BLINK_WRAP + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [FAULT_W-1:0] NO_FAULT = FAULT_W'(NUM_DEVICES);

  // blink phases at which a pulse sounds, first to fourth
  localparam logic [BLINK_W-1:0] PULSE_PH1 = BLINK_W'(1);
  localparam logic [BLINK_W-1:0] PULSE_PH2 = BLINK_W'(7);
  localparam logic [BLINK_W-1:0] PULSE_PH3 = BLINK_W'(13);
  localparam logic [BLINK_W-1:0] PULSE_PH4 = BLINK_W'(19);

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(200);
  localparam logic [NUM_DEVICES-1:0] ENABLE_RST = '1;
  localparam logic [LEVEL_W-1:0] BUZZER_RST = LEVEL_W'(400);

  typedef enum logic [1:0] {
    OP_HEARTBEAT = 2'd0,
    OP_TICK      = 2'd1,
    OP_SCAN      = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_ENABLE    = 2'd1,
    CFG_TONE_BASE = 2'd2,
    CFG_BUZZER_ON = 2'd3
  } cfg_index_t;

endpackage

[rtl/lhfm_ram.sv]
`timescale 1ns / 1ps
module lhfm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/link_heartbeat_fault_monitor_core.sv]
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid / in_ready  opcode, device_id
// out       out_valid / out_ready offline_mask, fault_id, red_led, green_led,
//                                buzzer_compare, beep_level, blink_phase
// cfg       cfg_we               cfg_index, cfg_data (write only)
//
// Heartbeat, tick and unused codes go straight from accept to the done state.
// A scan issues one last-seen memory read per device, compares each entry in the cycle
// after its read, then updates the flags, LEDs, buzzer and blink code in the finish state.
// Reset clears now_ms, the blink/LED/buzzer state and the per-entry valid bits;
// an entry never written reads as time zero.
// A result waits in the output register; the next request is taken meanwhile,
// and the block holds in its done state only while a second result is pending.
module link_heartbeat_fault_monitor_core
  import lhfm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic [2:0]             device_id,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             offline_mask,
  output logic [2:0]             fault_id,
  output logic                   red_led,
  output logic                   green_led,
  output logic [15:0]            buzzer_compare,
  output logic [14:0]            beep_level,
  output logic [5:0]             blink_phase,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state;

  logic [TIMEOUT_W-1:0]   timeout_ms;
  logic [NUM_DEVICES-1:0] enable_mask;
  logic [LEVEL_W-1:0]     tone_base;
  logic [LEVEL_W-1:0]     buzzer_on_level;

  logic [TIME_W-1:0]      now_ms;
  logic [NUM_DEVICES-1:0] seen_valid;
  logic [NUM_DEVICES-1:0] offline_flags;
  logic [FAULT_W-1:0]     cur_fault;
  logic [BLINK_W-1:0]     blink;
  logic                   red_state;
  logic                   green_state;
  logic [LEVEL_W-1:0]     buzzer_value;
  logic [BEEP_W-1:0]      beep_value;

  logic [FAULT_W-1:0]     scan_idx;
  logic                   cmp_vld;
  logic [DEV_W-1:0]       cmp_idx;
  logic [NUM_DEVICES-1:0] scan_flags;
  logic [FAULT_W-1:0]     scan_fault;

  logic                   accept;
  logic                   dev_ok;
  logic                   hb_we;
  logic [TIME_W-1:0]      rd_data;
  logic [TIME_W-1:0]      last_seen;
  logic [TIME_W-1:0]      silence;
  logic                   dev_stale;
  logic                   load_out;

  logic [BLINK_W:0]       blink_inc;
  logic [BLINK_W-1:0]     blink_next;
  logic                   pulse;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign dev_ok   = (device_id < 3'(NUM_DEVICES));
  assign hb_we    = accept && (opcode == OP_HEARTBEAT) && dev_ok
                    && enable_mask[device_id[DEV_W-1:0]];

  lhfm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_DEVICES)
  ) u_last_seen (
    .clk     (clk),
    .we      (hb_we),
    .wr_addr (device_id[DEV_W-1:0]),
    .wr_data (now_ms),
    .rd_addr (scan_idx[DEV_W-1:0]),
    .rd_data (rd_data)
  );

  // an entry never written stands for time zero
  assign last_seen = seen_valid[cmp_idx] ? rd_data : '0;
  assign silence   = now_ms - last_seen;
  assign dev_stale = enable_mask[cmp_idx] && (silence > TIME_W'(timeout_ms));

  assign blink_inc  = {1'b0, blink} + (BLINK_W + 1)'(1);
  assign blink_next = (blink_inc > (BLINK_W + 1)'(BLINK_WRAP)) ? '0
                                                               : blink_inc[BLINK_W-1:0];

  always_comb begin
    pulse = (blink_next == PULSE_PH1);
    if ((scan_fault >= FAULT_W'(2)) && (blink_next == PULSE_PH2)) begin
      pulse = 1'b1;
    end
    if ((scan_fault >= FAULT_W'(4)) && (blink_next == PULSE_PH3)) begin
      pulse = 1'b1;
    end
    if ((scan_fault >= FAULT_W'(5)) && (blink_next == PULSE_PH4)) begin
      pulse = 1'b1;
    end
  end

  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms      <= TIMEOUT_RST;
      enable_mask     <= ENABLE_RST;
      tone_base       <= '0;
      buzzer_on_level <= BUZZER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT:   timeout_ms      <= cfg_data[TIMEOUT_W-1:0];
        CFG_ENABLE:    enable_mask     <= cfg_data[NUM_DEVICES-1:0];
        CFG_TONE_BASE: tone_base       <= cfg_data[LEVEL_W-1:0];
        CFG_BUZZER_ON: buzzer_on_level <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      now_ms        <= '0;
      seen_valid    <= '0;
      offline_flags <= '0;
      cur_fault     <= NO_FAULT;
      blink         <= '0;
      red_state     <= 1'b0;
      green_state   <= 1'b0;
      buzzer_value  <= '0;
      beep_value    <= '0;
      scan_idx      <= '0;
      cmp_vld       <= 1'b0;
      cmp_idx       <= '0;
      scan_flags    <= '0;
      scan_fault    <= NO_FAULT;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_DONE;
            case (opcode)
              OP_HEARTBEAT: begin
                if (hb_we) begin
                  seen_valid[device_id[DEV_W-1:0]] <= 1'b1;
                end
              end
              OP_TICK: now_ms <= now_ms + TIME_W'(1);
              OP_SCAN: begin
                state      <= ST_SCAN;
                scan_idx   <= '0;
                cmp_vld    <= 1'b0;
                scan_flags <= '0;
                scan_fault <= NO_FAULT;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // issue the next read while the previous entry is compared
          if (scan_idx < FAULT_W'(NUM_DEVICES)) begin
            scan_idx <= scan_idx + FAULT_W'(1);
            cmp_idx  <= scan_idx[DEV_W-1:0];
            cmp_vld  <= 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld) begin
            if (dev_stale) begin
              scan_flags[cmp_idx] <= 1'b1;
              if (scan_fault == NO_FAULT) begin
                scan_fault <= FAULT_W'(cmp_idx);
              end
            end
            if (cmp_idx == DEV_W'(NUM_DEVICES - 1)) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          state         <= ST_DONE;
          offline_flags <= scan_flags;
          cur_fault     <= scan_fault;
          if (scan_fault == NO_FAULT) begin
            beep_value  <= '0;
            green_state <= 1'b1;
          end else begin
            blink <= blink_next;
            if (scan_fault <= FAULT_W'(1)) begin
              if (blink_next == PULSE_PH1) begin
                red_state    <= 1'b1;
                buzzer_value <= buzzer_on_level;
              end else begin
                red_state    <= 1'b0;
                buzzer_value <= '0;
                beep_value   <= '0;
              end
            end else if (scan_fault <= FAULT_W'(5)) begin
              if (pulse) begin
                red_state    <= 1'b1;
                beep_value   <= tone_base[LEVEL_W-1:1];
                buzzer_value <= buzzer_on_level;
              end else begin
                red_state  <= 1'b0;
                beep_value <= '0;
              end
            end else begin
              red_state  <= 1'b1;
              beep_value <= '0;
            end
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      offline_mask   <= offline_flags;
      fault_id       <= cur_fault;
      red_led        <= red_state;
      green_led      <= green_state;
      buzzer_compare <= buzzer_value;
      beep_level     <= beep_value;
      blink_phase    <= blink;
    end
  end

  a_fault_matches_flags: assert property (@(posedge clk) disable iff (rst)
    (cur_fault == NO_FAULT) == (offline_flags == '0))
    else $error("fault id disagrees with offline flags");

  a_fault_flag_set: assert property (@(posedge clk) disable iff (rst)
    (cur_fault == NO_FAULT) || offline_flags[cur_fault[DEV_W-1:0]])
    else $error("fault device not flagged offline");

  a_blink_range: assert property (@(posedge clk) disable iff (rst)
    blink <= BLINK_W'(BLINK_WRAP))
    else $error("blink counter past wrap");

  a_short_op_done: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode != OP_SCAN) |=> state == ST_DONE)
    else $error("non-scan request did not finish in one cycle");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && cmp_vld && (cmp_idx == DEV_W'(NUM_DEVICES - 1))
    |=> state == ST_FINISH)
    else $error("scan did not end after last device");

endmodule

[verif/lhfm_status_checker.sv]
`timescale 1ns / 1ps
module lhfm_status_checker
  import lhfm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             opcode,
  input  logic [2:0]             device_id,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [5:0]             offline_mask,
  input  logic [2:0]             fault_id,
  input  logic                   red_led,
  input  logic                   green_led,
  input  logic [15:0]            buzzer_compare,
  input  logic [14:0]            beep_level,
  input  logic [5:0]             blink_phase,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     pending,
  output int                     checked,
  output logic [NUM_DEVICES:0]   faults_seen
);

  typedef struct packed {
    logic [NUM_DEVICES-1:0] offline;
    logic [FAULT_W-1:0]     fault;
    logic                   red;
    logic                   green;
    logic [LEVEL_W-1:0]     buzzer;
    logic [BEEP_W-1:0]      beep;
    logic [BLINK_W-1:0]     blink;
  } status_t;

  status_t expected_status_q[$];

  // register copies
  logic [TIMEOUT_W-1:0]   timeout_lim;
  logic [NUM_DEVICES-1:0] watch_mask;
  logic [LEVEL_W-1:0]     tone;
  logic [LEVEL_W-1:0]     buzz_level;

  // predicted monitor state
  logic [TIME_W-1:0]      now_ms;
  logic [TIME_W-1:0]      last_seen [NUM_DEVICES];
  logic [NUM_DEVICES-1:0] offline;
  logic [FAULT_W-1:0]     fault;
  logic [BLINK_W-1:0]     blink;
  logic                   red;
  logic                   green;
  logic [LEVEL_W-1:0]     buzzer;
  logic [LEVEL_W-1:0]     beep;

  int                     mismatch_total = 0;
  int                     checked_total = 0;
  logic [NUM_DEVICES:0]   seen_faults = '0;

  task automatic reset_monitor();
    timeout_lim = TIMEOUT_RST;
    watch_mask  = ENABLE_RST;
    tone        = '0;
    buzz_level  = BUZZER_RST;
    now_ms      = '0;
    for (int i = 0; i < NUM_DEVICES; i++) last_seen[i] = '0;
    offline     = '0;
    fault       = NO_FAULT;
    blink       = '0;
    red         = 1'b0;
    green       = 1'b0;
    buzzer      = '0;
    beep        = '0;
  endtask

  function automatic bit pulse_due(input logic [BLINK_W-1:0] ph, input int pulses);
    return (ph == PULSE_PH1) || (pulses >= 2 && ph == PULSE_PH2) ||
           (pulses >= 3 && ph == PULSE_PH3) || (pulses >= 4 && ph == PULSE_PH4);
  endfunction

  function automatic status_t advance_monitor(input logic [1:0] op, input logic [2:0] dev);
    logic [TIME_W-1:0] silence;
    int                pulses;
    status_t           s;
    case (op)
      OP_HEARTBEAT: begin
        if (dev < NUM_DEVICES && watch_mask[dev]) last_seen[dev] = now_ms;
      end
      OP_TICK: now_ms = now_ms + 1'b1;
      OP_SCAN: begin
        offline = '0;
        fault   = NO_FAULT;
        for (int i = 0; i < NUM_DEVICES; i++) begin
          silence = now_ms - last_seen[i];
          if (watch_mask[i] && silence > TIME_W'(timeout_lim)) begin
            offline[i] = 1'b1;
            if (fault == NO_FAULT) fault = FAULT_W'(i);
          end
        end
        seen_faults[fault] = 1'b1;
        if (fault == NO_FAULT) begin
          beep  = '0;
          green = 1'b1;
        end else begin
          if (blink >= BLINK_W'(BLINK_WRAP)) blink = '0;
          else blink = blink + 1'b1;
          if (fault <= 1) begin
            // beep left as is on the pulse
            if (blink == PULSE_PH1) begin
              red    = 1'b1;
              buzzer = buzz_level;
            end else begin
              buzzer = '0;
              red    = 1'b0;
              beep   = '0;
            end
          end else if (fault <= 5) begin
            pulses = (fault <= 3) ? 2 : int'(fault) - 1;
            if (pulse_due(blink, pulses)) begin
              red    = 1'b1;
              beep   = tone >> 1;
              buzzer = buzz_level;
            end else begin
              red  = 1'b0;
              beep = '0;
            end
          end else begin
            red  = 1'b1;
            beep = '0;
          end
        end
      end
      default: ;
    endcase
    s.offline = offline;
    s.fault   = fault;
    s.red     = red;
    s.green   = green;
    s.buzzer  = buzzer;
    s.beep    = beep[BEEP_W-1:0];
    s.blink   = blink;
    return s;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_total++;
      if (mismatch_total <= 10)
        $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                 $realtime, name, checked_total, want, got);
    end
  endtask

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst) begin
      reset_monitor();
      expected_status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:   timeout_lim = cfg_data[TIMEOUT_W-1:0];
          CFG_ENABLE:    watch_mask  = cfg_data[NUM_DEVICES-1:0];
          CFG_TONE_BASE: tone        = cfg_data[LEVEL_W-1:0];
          CFG_BUZZER_ON: buzz_level  = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      // retire the oldest request before predicting a new one
      if (out_valid && out_ready) begin
        got = '{offline_mask, fault_id, red_led, green_led, buzzer_compare, beep_level,
                blink_phase};
        if (expected_status_q.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t: status result with no request outstanding", $realtime);
        end else begin
          want = expected_status_q.pop_front();
          check_field("offline_mask", want.offline, got.offline);
          check_field("fault_id", want.fault, got.fault);
          check_field("red_led", want.red, got.red);
          check_field("green_led", want.green, got.green);
          check_field("buzzer_compare", want.buzzer, got.buzzer);
          check_field("beep_level", want.beep, got.beep);
          check_field("blink_phase", want.blink, got.blink);
          checked_total++;
        end
      end
      if (in_valid && in_ready) expected_status_q.push_back(advance_monitor(opcode, device_id));
    end
    mismatches  <= mismatch_total;
    pending     <= expected_status_q.size();
    checked     <= checked_total;
    faults_seen <= seen_faults;
  end

endmodule

[verif/link_heartbeat_fault_monitor_core_test.sv]
`timescale 1ns / 1ps
module link_heartbeat_fault_monitor_core_test;
  import lhfm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int BLOCKS        = 13;
  localparam int BLOCK_ITEMS   = 50;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] dev;
  } request_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            opcode = OP_TICK;
  logic [2:0]            device_id = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [5:0]            offline_mask;
  logic [2:0]            fault_id;
  logic                  red_led;
  logic                  green_led;
  logic [15:0]           buzzer_compare;
  logic [14:0]           beep_level;
  logic [5:0]            blink_phase;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    mismatches;
  int                    pending;
  int                    checked;
  logic [NUM_DEVICES:0]  faults_seen;

  request_t              request_q[$];
  int                    queued_count = 0;
  int                    accepted_count = 0;
  int                    send_idle_pct = 31;
  int                    recv_idle_pct = 83;

  always #1 clk = ~clk;

  link_heartbeat_fault_monitor_core i_dut (.*);

  lhfm_status_checker i_checker (.*);

  // request driver: hold valid and payload until taken
  always @(posedge clk) begin
    request_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) accepted_count <= accepted_count + 1;
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req  = request_q.pop_front();
          in_valid  <= 1'b1;
          opcode    <= next_req.op;
          device_id <= next_req.dev;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic queue_request(input logic [1:0] op, input logic [2:0] dev);
    while (request_q.size() >= 2) @(posedge clk);
    request_q.push_back('{op, dev});
    queued_count++;
  endtask

  task automatic wait_idle(input int settle);
    while (accepted_count != queued_count) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] tmo, input logic [15:0] ena,
                              input logic [15:0] tune, input logic [15:0] buzz);
    wait_idle(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= CFG_ENABLE;
    cfg_data  <= ena;
    @(posedge clk);
    cfg_index <= CFG_TONE_BASE;
    cfg_data  <= tune;
    @(posedge clk);
    cfg_index <= CFG_BUZZER_ON;
    cfg_data  <= buzz;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) queue_request(OP_TICK, 3'($urandom_range(7)));
    else if (pick < 62) queue_request(OP_SCAN, 3'($urandom_range(7)));
    else if (pick < 95) begin
      if ($urandom_range(3) == 0) queue_request(OP_HEARTBEAT, 3'($urandom_range(7)));
      else queue_request(OP_HEARTBEAT, 3'($urandom_range(NUM_DEVICES - 1)));
    end else queue_request(OP_UNUSED, 3'($urandom_range(7)));
  endtask

  initial begin
    logic [15:0] tmo;
    logic [15:0] ena;
    int          quiet;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // healthy scan right after reset, then ignored requests and a tick
    queue_request(OP_SCAN, 3'd0);
    queue_request(OP_HEARTBEAT, 3'd7);
    queue_request(OP_HEARTBEAT, 3'd6);
    queue_request(OP_UNUSED, 3'd5);
    queue_request(OP_TICK, 3'd0);
    // zero timeout on device 0 alone: first pulse, then silent phase
    write_config(16'd0, 16'h0001, 16'hFFFF, 16'hFFFF);
    queue_request(OP_SCAN, 3'd0);
    queue_request(OP_SCAN, 3'd0);
    queue_request(OP_HEARTBEAT, 3'd0);
    queue_request(OP_SCAN, 3'd0);
    // lowest priority device alone
    write_config(16'd0, 16'h0020, 16'd1, 16'd0);
    queue_request(OP_SCAN, 3'd0);
    queue_request(OP_HEARTBEAT, 3'd5);
    queue_request(OP_SCAN, 3'd0);
    // nothing monitored: heartbeats dropped, scans stay healthy
    write_config(16'd0, 16'h0000, 16'h8000, 16'h0001);
    queue_request(OP_HEARTBEAT, 3'd2);
    queue_request(OP_TICK, 3'd0);
    queue_request(OP_SCAN, 3'd0);
    write_config(16'hFFFF, 16'h003F, 16'h7FFF, 16'h8000);
    queue_request(OP_TICK, 3'd0);
    queue_request(OP_SCAN, 3'd0);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk < 5) begin
        send_idle_pct = 31;
        recv_idle_pct = 83;
      end else if (blk < 9) begin
        send_idle_pct = 83;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      quiet = $urandom_range(NUM_DEVICES - 1);
      if (blk == 0) write_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      else if (blk == 1) write_config(16'hFFFF, 16'h0000, 16'd0, 16'hFFFF);
      else begin
        tmo = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        ena = 16'($urandom);
        // mask the devices ahead of the quiet one so lower priorities can fault
        if ($urandom_range(9) < 7) ena = ena & ~((16'd1 << quiet) - 16'd1);
        ena[quiet] = 1'b1;
        write_config(tmo, ena, 16'($urandom), 16'($urandom));
      end
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        // hold off the sender until every result is back
        if ($urandom_range(39) == 0) wait_idle(0);
        random_request();
      end
    end

    wait_idle(SETTLE_CYCLES);
    $display("%0d requests sent, %0d status results checked, fault codes seen %b",
             queued_count, checked, faults_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("link_heartbeat_fault_monitor_core_test OK");
    end else begin
      $display("link_heartbeat_fault_monitor_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("link_heartbeat_fault_monitor_core_test NOT OK");
    $finish;
  end

endmodule
